FILE: rtl/bspl_pkg.sv
// ----------------------------------------------------------------------------
// bspl_pkg: shared types and constants for the BSP leaf locate block
// Request and status codes, table records, and control structs.
// ----------------------------------------------------------------------------
package bspl_pkg;

  localparam int IDX_W   = 10;   // table index width
  localparam int CHILD_W = 11;   // signed child reference
  localparam int STEPS_W = 11;   // walk step count on the result
  localparam int COMP_W  = 32;   // Q16.16 component
  localparam int PROD_W  = 2 * COMP_W;
  localparam int ACC_W   = PROD_W + 2;  // three products plus offset, no overflow
  localparam int FRAC_W  = 16;

  localparam logic [STEPS_W-1:0] STEPS_MAX = {STEPS_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_PLANE  = 2'd0,
    REQ_NODE   = 2'd1,
    REQ_LOCATE = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_WRITE_OK = 2'd0,
    ST_LEAF     = 2'd1,
    ST_WALK_ERR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    LANE_X = 2'd0,
    LANE_Y = 2'd1,
    LANE_Z = 2'd2
  } lane_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NODE,
    S_PLANE,
    S_MUL_X,
    S_MUL_Y,
    S_MUL_Z,
    S_STEP,
    S_POST
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0]          plane;
    logic signed [CHILD_W-1:0] front;
    logic signed [CHILD_W-1:0] back;
  } node_rec_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] nx;
    logic signed [COMP_W-1:0] ny;
    logic signed [COMP_W-1:0] nz;
    logic signed [COMP_W-1:0] off;
  } plane_rec_t;

  typedef struct packed {
    logic             plane_we;
    logic             node_we;
    logic [IDX_W-1:0] idx;
  } tbl_wr_t;

  typedef struct packed {
    logic             node_en;
    logic [IDX_W-1:0] node_addr;
    logic             plane_en;
    logic [IDX_W-1:0] plane_addr;
  } tbl_rd_t;

  typedef struct packed {
    logic  mul_en;
    lane_e lane;
    logic  acc_init;
    logic  acc_en;
  } dist_ctl_t;

endpackage

FILE: rtl/bspl_chan_if.sv
// ----------------------------------------------------------------------------
// bspl_chan_if: request and result channels of the BSP leaf locate block
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bspl_req_if;
  logic                                       valid;
  logic                                       ready;
  logic [1:0]                                 req_type;
  logic [bspl_pkg::IDX_W-1:0]                 entry_index;
  logic signed [bspl_pkg::COMP_W-1:0]         vec_x;
  logic signed [bspl_pkg::COMP_W-1:0]         vec_y;
  logic signed [bspl_pkg::COMP_W-1:0]         vec_z;
  logic signed [bspl_pkg::COMP_W-1:0]         plane_offset;
  logic [bspl_pkg::IDX_W-1:0]                 split_plane;
  logic signed [bspl_pkg::CHILD_W-1:0]        front_child;
  logic signed [bspl_pkg::CHILD_W-1:0]        back_child;

  modport source (
    output valid, req_type, entry_index, vec_x, vec_y, vec_z, plane_offset,
           split_plane, front_child, back_child,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, vec_x, vec_y, vec_z, plane_offset,
           split_plane, front_child, back_child,
    output ready
  );
endinterface

interface bspl_res_if;
  logic                           valid;
  logic                           ready;
  logic [bspl_pkg::IDX_W-1:0]     leaf_index;
  logic [1:0]                     status;
  logic [bspl_pkg::STEPS_W-1:0]   walk_steps;

  modport source (output valid, leaf_index, status, walk_steps, input ready);
  modport sink   (input valid, leaf_index, status, walk_steps, output ready);
endinterface

FILE: rtl/bspl_tables.sv
// ----------------------------------------------------------------------------
// bspl_tables: plane and node tables
// One write port and one registered read port per table; out-of-range
// entries read as all zero.
// ----------------------------------------------------------------------------
module bspl_tables #(
  parameter int MAX_NODES  = 1024,
  parameter int MAX_PLANES = 1024
) (
  input  logic                 clk,
  input  bspl_pkg::tbl_wr_t    wr,
  input  bspl_pkg::node_rec_t  node_wdata,
  input  bspl_pkg::plane_rec_t plane_wdata,
  input  bspl_pkg::tbl_rd_t    rd,
  output bspl_pkg::node_rec_t  node,
  output bspl_pkg::plane_rec_t plane
);
  import bspl_pkg::*;

  localparam int IDX_SPAN    = 1 << IDX_W;
  localparam int NODE_DEPTH  = (MAX_NODES < IDX_SPAN) ? MAX_NODES : IDX_SPAN;
  localparam int PLANE_DEPTH = (MAX_PLANES < IDX_SPAN) ? MAX_PLANES : IDX_SPAN;
  localparam int NA = $clog2(NODE_DEPTH);
  localparam int PA = $clog2(PLANE_DEPTH);

  node_rec_t  node_mem  [NODE_DEPTH];
  plane_rec_t plane_mem [PLANE_DEPTH];

  node_rec_t  node_q_r;
  plane_rec_t plane_q_r;
  logic       node_ok_r;
  logic       plane_ok_r;

  logic node_wr_ok;
  logic plane_wr_ok;

  assign node_wr_ok  = 32'(wr.idx) < MAX_NODES;
  assign plane_wr_ok = 32'(wr.idx) < MAX_PLANES;

  always_ff @(posedge clk) begin
    if (wr.node_we && node_wr_ok) begin
      node_mem[wr.idx[NA-1:0]] <= node_wdata;
    end
    if (rd.node_en) begin
      node_q_r  <= node_mem[rd.node_addr[NA-1:0]];
      node_ok_r <= 32'(rd.node_addr) < MAX_NODES;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.plane_we && plane_wr_ok) begin
      plane_mem[wr.idx[PA-1:0]] <= plane_wdata;
    end
    if (rd.plane_en) begin
      plane_q_r  <= plane_mem[rd.plane_addr[PA-1:0]];
      plane_ok_r <= 32'(rd.plane_addr) < MAX_PLANES;
    end
  end

  // out-of-range reads answer an all-zero record
  assign node  = node_ok_r  ? node_q_r  : '0;
  assign plane = plane_ok_r ? plane_q_r : '0;

endmodule

FILE: rtl/bspl_dist.sv
// ----------------------------------------------------------------------------
// bspl_dist: shared signed-distance unit
// One 32x32 multiplier and one wide accumulator, stepped over x, y, z.
// ----------------------------------------------------------------------------
module bspl_dist (
  input  logic                                clk,
  input  bspl_pkg::dist_ctl_t                 ctl,
  input  bspl_pkg::plane_rec_t                plane,
  input  logic signed [bspl_pkg::COMP_W-1:0]  px,
  input  logic signed [bspl_pkg::COMP_W-1:0]  py,
  input  logic signed [bspl_pkg::COMP_W-1:0]  pz,
  output logic                                behind
);
  import bspl_pkg::*;

  logic signed [COMP_W-1:0] n_sel;
  logic signed [COMP_W-1:0] p_sel;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  off_ext;

  always_comb begin
    unique case (ctl.lane)
      LANE_X: begin
        n_sel = plane.nx;
        p_sel = px;
      end
      LANE_Y: begin
        n_sel = plane.ny;
        p_sel = py;
      end
      LANE_Z: begin
        n_sel = plane.nz;
        p_sel = pz;
      end
      default: begin
        n_sel = '0;
        p_sel = '0;
      end
    endcase
  end

  assign prod_nxt = n_sel * p_sel;
  assign off_ext  = {{(ACC_W-COMP_W-FRAC_W){plane.off[COMP_W-1]}}, plane.off,
                     {FRAC_W{1'b0}}};
  assign acc_sum  = acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign behind   = acc_sum[ACC_W-1];

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctl.acc_init) begin
      acc_r <= -off_ext;
    end else if (ctl.acc_en) begin
      acc_r <= acc_sum;
    end
  end

endmodule

FILE: rtl/bsp_point_leaf_locate.sv
// ----------------------------------------------------------------------------
// bsp_point_leaf_locate: BSP tree point location
// Loads plane and node tables and walks the tree to the leaf holding a point.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries one request per beat: write plane, write node, or locate.
//   Every request returns exactly one result beat on out_res.
//   Writes land in the tables at the accepting edge and answer status 0
//   through the pending-result and output registers.
//   A locate walks the tree from node 0. For each visited node the
//   sequencer steps in order through node table read, plane table read, three
//   passes through the single shared 32x32 multiplier, and the final
//   accumulate and branch. A walk visits at most MAX_NODES nodes; the next
//   request waits until it ends.
//   in_req.ready is high only while the sequencer is idle and out of reset;
//   a finished result parks in the output register, so the next request is
//   taken even while the receiver stalls. A further result then waits until
//   that register drains.
//   Reset clears the sequencer and the output valid flag; table contents are
//   not cleared and must be written before they are walked.
// ----------------------------------------------------------------------------
module bsp_point_leaf_locate #(
  parameter int MAX_NODES  = 1024,
  parameter int MAX_PLANES = 1024,
  parameter int MAX_LEAVES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  bspl_req_if.sink   in_req,
  bspl_res_if.source out_res
);
  import bspl_pkg::*;

  localparam int CNT_W = $clog2(MAX_NODES + 1);

  // sequencer state
  state_e              state_r, state_nxt;
  logic [IDX_W-1:0]    cur_r, cur_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  // pending result, then output register
  logic [IDX_W-1:0]    res_leaf_r, res_leaf_nxt;
  status_e             res_status_r, res_status_nxt;
  logic [STEPS_W-1:0]  res_steps_r, res_steps_nxt;
  logic                out_valid_r;
  logic [IDX_W-1:0]    out_leaf_r;
  status_e             out_status_r;
  logic [STEPS_W-1:0]  out_steps_r;
  logic                load_out;

  // point under test
  logic signed [COMP_W-1:0] px_r, py_r, pz_r;

  logic       in_acc;
  req_type_e  req;
  tbl_wr_t    wr;
  tbl_rd_t    rd;
  dist_ctl_t  ctl;
  node_rec_t  node;
  plane_rec_t plane;
  node_rec_t  node_wdata;
  plane_rec_t plane_wdata;
  logic       behind;

  logic signed [CHILD_W-1:0] child_sel;
  logic [IDX_W-1:0]          leaf_num;
  logic [CNT_W-1:0]          cnt_inc;
  logic [STEPS_W-1:0]        steps_sat;

  // hold off requests while reset is asserted
  assign in_req.ready = rst_n && (state_r == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign req          = req_type_e'(in_req.req_type);

  // table writes take effect at the accepting edge
  assign wr.plane_we = in_acc && (req == REQ_PLANE);
  assign wr.node_we  = in_acc && (req == REQ_NODE);
  assign wr.idx      = in_req.entry_index;

  assign node_wdata.plane = in_req.split_plane;
  assign node_wdata.front = in_req.front_child;
  assign node_wdata.back  = in_req.back_child;

  assign plane_wdata.nx  = in_req.vec_x;
  assign plane_wdata.ny  = in_req.vec_y;
  assign plane_wdata.nz  = in_req.vec_z;
  assign plane_wdata.off = in_req.plane_offset;

  bspl_tables #(
    .MAX_NODES  (MAX_NODES),
    .MAX_PLANES (MAX_PLANES)
  ) u_tables (
    .clk         (clk),
    .wr          (wr),
    .node_wdata  (node_wdata),
    .plane_wdata (plane_wdata),
    .rd          (rd),
    .node        (node),
    .plane       (plane)
  );

  bspl_dist u_dist (
    .clk    (clk),
    .ctl    (ctl),
    .plane  (plane),
    .px     (px_r),
    .py     (py_r),
    .pz     (pz_r),
    .behind (behind)
  );

  // branch decision: a negative distance takes the back child
  assign child_sel = behind ? node.back : node.front;
  // a negative child c names leaf -(c+1), which is its bitwise inverse
  assign leaf_num  = ~child_sel[IDX_W-1:0];
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign steps_sat = (32'(cnt_inc) > 32'(STEPS_MAX)) ? STEPS_MAX : STEPS_W'(cnt_inc);

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    cnt_nxt        = cnt_r;
    res_leaf_nxt   = res_leaf_r;
    res_status_nxt = res_status_r;
    res_steps_nxt  = res_steps_r;
    rd             = '0;
    ctl            = '0;
    ctl.lane       = LANE_X;
    load_out       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (req == REQ_LOCATE) begin
            cur_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_NODE;
          end else begin
            // writes and the unused code answer a plain acknowledge
            res_leaf_nxt   = '0;
            res_status_nxt = ST_WRITE_OK;
            res_steps_nxt  = '0;
            state_nxt      = S_POST;
          end
        end
      end
      S_NODE: begin
        rd.node_en   = 1'b1;
        rd.node_addr = cur_r;
        state_nxt    = S_PLANE;
      end
      S_PLANE: begin
        rd.plane_en   = 1'b1;
        rd.plane_addr = node.plane;
        state_nxt     = S_MUL_X;
      end
      S_MUL_X: begin
        ctl.mul_en   = 1'b1;
        ctl.lane     = LANE_X;
        ctl.acc_init = 1'b1;
        state_nxt    = S_MUL_Y;
      end
      S_MUL_Y: begin
        ctl.mul_en = 1'b1;
        ctl.lane   = LANE_Y;
        ctl.acc_en = 1'b1;
        state_nxt  = S_MUL_Z;
      end
      S_MUL_Z: begin
        ctl.mul_en = 1'b1;
        ctl.lane   = LANE_Z;
        ctl.acc_en = 1'b1;
        state_nxt  = S_STEP;
      end
      S_STEP: begin
        cnt_nxt       = cnt_inc;
        res_steps_nxt = steps_sat;
        if (child_sel[CHILD_W-1]) begin
          // reached a leaf; leaf numbers past the leaf table are an error
          if (32'(leaf_num) < MAX_LEAVES) begin
            res_leaf_nxt   = leaf_num;
            res_status_nxt = ST_LEAF;
          end else begin
            res_leaf_nxt   = '0;
            res_status_nxt = ST_WALK_ERR;
          end
          state_nxt = S_POST;
        end else if (32'(cnt_inc) == MAX_NODES) begin
          // walk limit hit without a leaf
          res_leaf_nxt   = '0;
          res_status_nxt = ST_WALK_ERR;
          state_nxt      = S_POST;
        end else begin
          cur_nxt   = child_sel[IDX_W-1:0];
          state_nxt = S_NODE;
        end
      end
      S_POST: begin
        // hold until the output register is free or draining this cycle
        if (!out_valid_r || out_res.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // pending result and point registers carry payload only
  always_ff @(posedge clk) begin
    res_leaf_r   <= res_leaf_nxt;
    res_status_r <= res_status_nxt;
    res_steps_r  <= res_steps_nxt;
    if (in_acc && (req == REQ_LOCATE)) begin
      px_r <= in_req.vec_x;
      py_r <= in_req.vec_y;
      pz_r <= in_req.vec_z;
    end
  end

  // output register: load from the pending result, drop on a taken beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_leaf_r   <= res_leaf_r;
      out_status_r <= res_status_r;
      out_steps_r  <= res_steps_r;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.leaf_index = out_leaf_r;
  assign out_res.status     = out_status_r;
  assign out_res.walk_steps = out_steps_r;

endmodule

FILE: tb/tb_bsp_point_leaf_locate.sv
// ----------------------------------------------------------------------------
// tb_bsp_point_leaf_locate: self-checking bench for the BSP leaf locate block
// Loads plane and node tables, locates points, and checks every result beat
// against an in-bench walk of the same tree in exact wide fixed point.
// ----------------------------------------------------------------------------
module tb_bsp_point_leaf_locate;
  timeunit 1ns;
  timeprecision 1ps;

  import bspl_pkg::*;

  localparam int NODE_CNT     = 1024;
  localparam int PLANE_CNT    = 1024;
  localparam int LEAF_CNT     = 1024;
  localparam int RAND_ITEMS   = 2000;
  localparam int IDLE_PCT     = 6;
  localparam int QUIET_LIMIT  = 40000;  // well beyond a full-length walk
  localparam int DRAIN_CYCLES = 32;

  localparam logic signed [COMP_W-1:0] Q_MIN  = 32'sh8000_0000;
  localparam logic signed [COMP_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [COMP_W-1:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [COMP_W-1:0] Q_FIVE = 32'sh0005_0000;

  typedef struct {
    req_type_e                 kind;
    logic [IDX_W-1:0]          idx;
    logic signed [COMP_W-1:0]  x;
    logic signed [COMP_W-1:0]  y;
    logic signed [COMP_W-1:0]  z;
    logic signed [COMP_W-1:0]  off;
    logic [IDX_W-1:0]          plane;
    logic signed [CHILD_W-1:0] front;
    logic signed [CHILD_W-1:0] back;
  } bsp_req_t;

  typedef struct {
    logic [IDX_W-1:0]   leaf;
    status_e            status;
    logic [STEPS_W-1:0] steps;
  } leaf_res_t;

  // Shadow copy of both tables; every accepted request is replayed here in
  // order and the answer it must produce is queued.
  class leaf_tracker;
    plane_rec_t planes[PLANE_CNT];
    node_rec_t  nodes[NODE_CNT];
    leaf_res_t  leaves_due[$];
    int         errors;

    function void take_request(bsp_req_t r);
      leaf_res_t          want;
      node_rec_t          nd;
      plane_rec_t         pl;
      logic signed [67:0] wx, wy, wz, wo, px, py, pz, sdist;
      int                 cur, hops;
      want = '{leaf: '0, status: ST_WRITE_OK, steps: '0};
      case (r.kind)
        REQ_PLANE: planes[r.idx] = '{nx: r.x, ny: r.y, nz: r.z, off: r.off};
        REQ_NODE:  nodes[r.idx] = '{plane: r.plane, front: r.front, back: r.back};
        REQ_LOCATE: begin
          px = r.x;
          py = r.y;
          pz = r.z;
          cur = 0;
          hops = 0;
          while (cur >= 0 && hops < NODE_CNT) begin
            nd = nodes[cur];
            pl = planes[nd.plane];
            wx = pl.nx;
            wy = pl.ny;
            wz = pl.nz;
            wo = pl.off;
            // Q32.32 distance, wide enough that no term overflows
            sdist = wx * px + wy * py + wz * pz - (wo <<< FRAC_W);
            cur = sdist[67] ? int'(nd.back) : int'(nd.front);
            hops++;
          end
          want.steps = STEPS_W'(hops);
          if (cur >= 0) begin
            want.status = ST_WALK_ERR;
          end else if (-(cur + 1) < LEAF_CNT) begin
            want.leaf   = IDX_W'(-(cur + 1));
            want.status = ST_LEAF;
          end else begin
            want.status = ST_WALK_ERR;
          end
        end
        default: ;
      endcase
      leaves_due = {leaves_due, want};
    endfunction

    function void match_result(logic [IDX_W-1:0] leaf, logic [1:0] status,
                               logic [STEPS_W-1:0] steps);
      leaf_res_t want;
      if (leaves_due.size() == 0) begin
        errors++;
        $error("result beat with no request outstanding");
        return;
      end
      want = leaves_due.pop_front();
      if (leaf !== want.leaf) begin
        errors++;
        $error("leaf_index: expected %0d, got %0d", want.leaf, leaf);
      end
      if (status !== want.status) begin
        errors++;
        $error("status: expected %0d, got %0d", want.status, status);
      end
      if (steps !== want.steps) begin
        errors++;
        $error("walk_steps: expected %0d, got %0d", want.steps, steps);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;            // when set, neither side idles

  bspl_req_if req_bus();
  bspl_res_if res_bus();

  leaf_tracker tracker = new();

  // Stimulus-side bookkeeping: which entries hold data. Locates only ever
  // walk entries marked here, so the undefined table contents stay unread.
  bit node_set[NODE_CNT];
  bit plane_set[PLANE_CNT];
  int plane_list[$];

  bsp_point_leaf_locate #(
    .MAX_NODES  (NODE_CNT),
    .MAX_PLANES (PLANE_CNT),
    .MAX_LEAVES (LEAF_CNT)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus),
    .out_res (res_bus)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Component values: mostly full-range, a good share of small Q16.16
  // magnitudes so that distances land near zero, and the extremes.
  function automatic logic signed [COMP_W-1:0] rand_comp();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      case ($urandom_range(4))
        0:       return Q_MIN;
        1:       return Q_MAX;
        2:       return '0;
        3:       return -32'sd1;
        default: return Q_ONE;
      endcase
    end
    if (sel < 40) return COMP_W'(int'($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
    return $urandom();
  endfunction

  // Every field random; callers override the ones the request uses.
  function automatic bsp_req_t random_req();
    bsp_req_t r;
    r.kind  = req_type_e'(2'($urandom_range(3)));
    r.idx   = IDX_W'($urandom());
    r.x     = $urandom();
    r.y     = $urandom();
    r.z     = $urandom();
    r.off   = $urandom();
    r.plane = IDX_W'($urandom());
    r.front = CHILD_W'($urandom());
    r.back  = CHILD_W'($urandom());
    return r;
  endfunction

  // Child of node j: a leaf, or a written node with a higher index. Keeping
  // children above their parent makes the random tree acyclic, so random
  // walks end; the nearest higher node is favored to build long chains.
  function automatic logic signed [CHILD_W-1:0] pick_child(int j);
    int above[$];
    if ($urandom_range(99) < 20) return CHILD_W'(-1 - int'($urandom_range(LEAF_CNT - 1)));
    for (int k = j + 1; k < NODE_CNT; k++)
      if (node_set[k]) above = {above, k};
    if (above.size() == 0) return CHILD_W'(-1 - int'($urandom_range(LEAF_CNT - 1)));
    if ($urandom_range(1) == 1) return CHILD_W'(above[0]);
    return CHILD_W'(above[$urandom_range(above.size() - 1)]);
  endfunction

  // Present one beat and hold it until the block takes it. Called at a
  // rising edge; valid is left high so a following beat can go back to back.
  task automatic send_req(bsp_req_t r);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.req_type     <= r.kind;
    req_bus.entry_index  <= r.idx;
    req_bus.vec_x        <= r.x;
    req_bus.vec_y        <= r.y;
    req_bus.vec_z        <= r.z;
    req_bus.plane_offset <= r.off;
    req_bus.split_plane  <= r.plane;
    req_bus.front_child  <= r.front;
    req_bus.back_child   <= r.back;
    do @(posedge clk); while (!req_bus.ready);
    tracker.take_request(r);
  endtask

  task automatic put_plane(int idx, logic signed [COMP_W-1:0] nx,
                           logic signed [COMP_W-1:0] ny, logic signed [COMP_W-1:0] nz,
                           logic signed [COMP_W-1:0] off);
    bsp_req_t r;
    r = random_req();
    r.kind = REQ_PLANE;
    r.idx  = IDX_W'(idx);
    r.x    = nx;
    r.y    = ny;
    r.z    = nz;
    r.off  = off;
    if (!plane_set[idx]) plane_list = {plane_list, idx};
    plane_set[idx] = 1'b1;
    send_req(r);
  endtask

  task automatic put_node(int idx, int plane, logic signed [CHILD_W-1:0] front,
                          logic signed [CHILD_W-1:0] back);
    bsp_req_t r;
    r = random_req();
    r.kind  = REQ_NODE;
    r.idx   = IDX_W'(idx);
    r.plane = IDX_W'(plane);
    r.front = front;
    r.back  = back;
    node_set[idx] = 1'b1;
    send_req(r);
  endtask

  task automatic put_locate(logic signed [COMP_W-1:0] x, logic signed [COMP_W-1:0] y,
                            logic signed [COMP_W-1:0] z);
    bsp_req_t r;
    r = random_req();
    r.kind = REQ_LOCATE;
    r.x    = x;
    r.y    = y;
    r.z    = z;
    send_req(r);
  endtask

  task automatic put_noise();
    bsp_req_t r;
    r = random_req();
    r.kind = REQ_NONE;
    send_req(r);
  endtask

  // Drop valid and hold off until every outstanding answer has come back.
  task automatic hold_until_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (tracker.leaves_due.size() != 0);
  endtask

  // Request side: reset, directed corners, then the random tree workload.
  initial begin
    int pick, j;
    calm = 1'b0;
    rst_n                <= 1'b0;
    req_bus.valid        <= 1'b0;
    req_bus.req_type     <= REQ_NONE;
    req_bus.entry_index  <= '0;
    req_bus.vec_x        <= '0;
    req_bus.vec_y        <= '0;
    req_bus.vec_z        <= '0;
    req_bus.plane_offset <= '0;
    req_bus.split_plane  <= '0;
    req_bus.front_child  <= '0;
    req_bus.back_child   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Planes: x = 0, an all-zero plane, both extreme planes, and x = 5.0.
    put_plane(0, Q_ONE, '0, '0, '0);
    put_plane(1, '0, '0, '0, '0);
    put_plane(2, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    put_plane(PLANE_CNT - 1, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    put_plane(3, Q_ONE, '0, '0, Q_FIVE);

    // Root splits on x = 0 into the lowest and highest leaf numbers.
    put_node(0, 0, -1, -1024);
    put_locate('0, '0, '0);             // exactly on the plane: front side
    put_locate(-32'sd1, Q_MAX, Q_MIN);  // one LSB behind
    put_locate(Q_MAX, '0, '0);

    // Boundary with a nonzero offset: on the plane and one LSB short of it.
    put_node(0, 3, -2, -3);
    put_locate(Q_FIVE, '0, '0);
    put_locate(Q_FIVE - 32'sd1, Q_MAX, Q_MAX);

    // Two-level tree through the top node and plane entries, probed with extreme
    // points whose products only fit in the wide sum.
    put_node(NODE_CNT - 1, PLANE_CNT - 1, -2, -3);
    put_node(0, 2, NODE_CNT - 1, -513);
    put_locate(Q_MIN, Q_MIN, Q_MIN);
    put_locate(Q_MAX, Q_MAX, Q_MAX);

    // Root pointing at itself: the walk runs out of steps.
    put_node(0, 1, 0, 0);
    put_locate(rand_comp(), rand_comp(), rand_comp());

    put_noise();

    // Back to an acyclic root before the random part.
    put_node(0, 0, -1, -2);
    put_locate(32'sd1, 32'sd1, 32'sd1);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= 900 && n < 1300);
      if (n == 600 || n == 1500) hold_until_drained();
      pick = $urandom_range(99);
      if (pick < 20) begin
        put_plane($urandom_range(PLANE_CNT - 1), rand_comp(), rand_comp(), rand_comp(),
                  rand_comp());
      end else if (pick < 50) begin
        j = $urandom_range(NODE_CNT - 1);
        put_node(j, plane_list[$urandom_range(plane_list.size() - 1)], pick_child(j),
                 pick_child(j));
      end else if (pick < 96) begin
        put_locate(rand_comp(), rand_comp(), rand_comp());
      end else begin
        put_noise();
      end
    end
    calm = 1'b0;
    req_bus.valid <= 1'b0;

    // Drain, then keep watching for any stray beat before the verdict.
    while (tracker.leaves_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.leaves_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result side: check each beat taken at this edge, then pick next ready.
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_bus.valid && res_bus.ready) begin
        tracker.match_result(res_bus.leaf_index, res_bus.status, res_bus.walk_steps);
      end
      res_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: too long without a beat on either channel means a hang.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bspl_pkg.sv
rtl/bspl_chan_if.sv
rtl/bspl_tables.sv
rtl/bspl_dist.sv
rtl/bsp_point_leaf_locate.sv
tb/tb_bsp_point_leaf_locate.sv
